FILE: design/bpec_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers for the disc collision core.
// No dependencies; every other design file imports this package.
package bpec_pkg;

	localparam int COORD_W   = 24;   // signed position / velocity
	localparam int RAD_W     = 16;   // unsigned radius (and mass)
	localparam int DIFF_W    = 25;   // difference of two coordinates
	localparam int RSUM_W    = 17;   // radius sum
	localparam int SQ_W      = 49;   // one squared difference
	localparam int DIST2_W   = 50;   // squared centre distance
	localparam int D2_KEEP_W = 34;   // squared distance while overlapping
	localparam int RS2_W     = 34;   // squared radius sum

	localparam int SQRT_IN_W  = 62;  // squared distance scaled by 2^28
	localparam int SQRT_SHIFT = 28;
	localparam int ROOT_W     = 31;
	localparam int ROOT_REM_W = 34;

	localparam int DIV_N_W = 62;     // dividend
	localparam int DIV_D_W = 31;     // divisor
	localparam int DIV_Q_W = 47;     // quotient bits, one per stage

	localparam int NORM_SHIFT  = 30; // dividend shift for the unit normal
	localparam int DEPTH_SHIFT = 14; // extra fraction bits of the distance
	localparam int GAIN_W      = 17;
	localparam logic [GAIN_W-1:0] SEP_GAIN = 17'd65602; // 1.001 in Q1.16
	localparam int OFF_SHIFT   = 17;
	localparam int MOVE_SHIFT  = 30;
	localparam int IMP_SHIFT   = 32;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam int RND_W = 68;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_pos_x;
		logic signed [COORD_W-1:0] first_pos_y;
		logic signed [COORD_W-1:0] first_vel_x;
		logic signed [COORD_W-1:0] first_vel_y;
		logic        [RAD_W-1:0]   first_radius;
		logic signed [COORD_W-1:0] second_pos_x;
		logic signed [COORD_W-1:0] second_pos_y;
		logic signed [COORD_W-1:0] second_vel_x;
		logic signed [COORD_W-1:0] second_vel_y;
		logic        [RAD_W-1:0]   second_radius;
	} pair_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_first_pos_x;
		logic signed [COORD_W-1:0] new_first_pos_y;
		logic signed [COORD_W-1:0] new_first_vel_x;
		logic signed [COORD_W-1:0] new_first_vel_y;
		logic signed [COORD_W-1:0] new_second_pos_x;
		logic signed [COORD_W-1:0] new_second_pos_y;
		logic signed [COORD_W-1:0] new_second_vel_x;
		logic signed [COORD_W-1:0] new_second_vel_y;
		logic                      overlapping;
		logic                      degenerate;
	} result_t;

	// Classified request handed from the front to the back through the queue
	typedef struct packed {
		pair_t                      disc;
		logic signed [DIFF_W-1:0]   dx;
		logic signed [DIFF_W-1:0]   dy;
		logic        [D2_KEEP_W-1:0] d2;
		logic        [RSUM_W-1:0]   rs;
		logic                       ov;
		logic                       deg;
	} item_t;

	// Divide by 2^sh, round to nearest with ties away from zero
	function automatic logic signed [RND_W-1:0] round_shift(
		input logic signed [RND_W-1:0] v,
		input int unsigned             sh
	);
		logic [RND_W-1:0] mag;
		logic [RND_W-1:0] q;
		mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
		q = (mag + (RND_W'(1) << (sh - 1))) >> sh;
		return v[RND_W-1] ? -$signed(q) : $signed(q);
	endfunction

	localparam logic signed [39:0] SAT_MAX = 40'sd8388607;
	localparam logic signed [39:0] SAT_MIN = -40'sd8388608;

	// Clamp to the 24-bit signed range
	function automatic logic signed [COORD_W-1:0] sat24(input logic signed [39:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[COORD_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: design/bpec_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for disc pairs and collision results.
// Depends on bpec_pkg for the payload types.
interface bpec_pair_if;
	import bpec_pkg::*;
	logic  valid;
	logic  ready;
	pair_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bpec_result_if;
	import bpec_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/bpec_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
// Depends on bpec_pkg; all stages advance together while en is high.
module bpec_isqrt import bpec_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SQRT_IN_W-1:0] x,
	output logic [ROOT_W-1:0]    root
);

	logic [ROOT_REM_W-1:0] rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0]     root_s [0:ROOT_W-1];
	logic [SQRT_IN_W-1:0]  bits_s [0:ROOT_W-1];

	logic [ROOT_REM_W-1:0] rem_n  [0:ROOT_W-1];
	logic [ROOT_W-1:0]     root_n [0:ROOT_W-1];
	logic [SQRT_IN_W-1:0]  bits_n [0:ROOT_W-1];

	// Try one more root bit against the next pair of radicand bits
	always_comb begin
		logic [ROOT_REM_W-1:0] rem_i;
		logic [ROOT_W-1:0]     root_i;
		logic [SQRT_IN_W-1:0]  bits_i;
		logic [ROOT_REM_W+1:0] t;
		logic [ROOT_REM_W+1:0] trial;
		logic                  ge;
		for (int i = 0; i < ROOT_W; i++) begin
			if (i == 0) begin
				rem_i  = '0;
				root_i = '0;
				bits_i = x;
			end else begin
				rem_i  = rem_s[i-1];
				root_i = root_s[i-1];
				bits_i = bits_s[i-1];
			end
			t     = {rem_i, bits_i[SQRT_IN_W-1 -: 2]};
			trial = (ROOT_REM_W+2)'({root_i, 2'b01});
			ge    = (t >= trial);
			rem_n[i]  = ge ? ROOT_REM_W'(t - trial) : ROOT_REM_W'(t);
			root_n[i] = {root_i[ROOT_W-2:0], ge};
			bits_n[i] = bits_i << 2;
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ROOT_W; i++) begin
				rem_s[i]  <= rem_n[i];
				root_s[i] <= root_n[i];
				bits_s[i] <= bits_n[i];
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

FILE: design/bpec_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bpec_pkg; all stages advance together while en is high.
module bpec_div import bpec_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic [DIV_Q_W-1:0] quo
);

	logic [DIV_D_W-1:0] rem_s [0:DIV_Q_W-1];
	logic [DIV_Q_W-1:0] quo_s [0:DIV_Q_W-1];
	logic [DIV_Q_W-1:0] low_s [0:DIV_Q_W-1];
	logic [DIV_D_W-1:0] den_s [0:DIV_Q_W-1];

	logic [DIV_D_W-1:0] rem_n [0:DIV_Q_W-1];
	logic [DIV_Q_W-1:0] quo_n [0:DIV_Q_W-1];
	logic [DIV_Q_W-1:0] low_n [0:DIV_Q_W-1];
	logic [DIV_D_W-1:0] den_n [0:DIV_Q_W-1];

	// Shift in one dividend bit and subtract the divisor where it fits
	always_comb begin
		logic [DIV_D_W-1:0] rem_i;
		logic [DIV_Q_W-1:0] quo_i;
		logic [DIV_Q_W-1:0] low_i;
		logic [DIV_D_W-1:0] den_i;
		logic [DIV_D_W:0]   t;
		logic               ge;
		for (int i = 0; i < DIV_Q_W; i++) begin
			if (i == 0) begin
				rem_i = DIV_D_W'(num[DIV_N_W-1:DIV_Q_W]);
				quo_i = '0;
				low_i = num[DIV_Q_W-1:0];
				den_i = den;
			end else begin
				rem_i = rem_s[i-1];
				quo_i = quo_s[i-1];
				low_i = low_s[i-1];
				den_i = den_s[i-1];
			end
			t  = {rem_i, low_i[DIV_Q_W-1]};
			ge = (t >= {1'b0, den_i});
			rem_n[i] = ge ? DIV_D_W'(t - {1'b0, den_i}) : t[DIV_D_W-1:0];
			quo_n[i] = {quo_i[DIV_Q_W-2:0], ge};
			low_n[i] = low_i << 1;
			den_n[i] = den_i;
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_Q_W; i++) begin
				rem_s[i] <= rem_n[i];
				quo_s[i] <= quo_n[i];
				low_s[i] <= low_n[i];
				den_s[i] <= den_n[i];
			end
		end
	end

	assign quo = quo_s[DIV_Q_W-1];

endmodule

FILE: design/bpec_front.sv
`timescale 1ns / 1ps
// Front end: accepts disc pairs, computes squared distance and classifies them.
// Depends on bpec_pkg and bpec_if; feeds bpec_fifo.
module bpec_front import bpec_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bpec_pair_if.sink     pair,
	output logic          push,
	output item_t         item,
	input  logic          full
);

	logic                    v_s1, v_s2, v_s3;
	item_t                   it_s1, it_s2, it_s3;
	item_t                   it_n1, it_n3;
	logic [SQ_W-1:0]         sqx_s2, sqy_s2;
	logic [RS2_W-1:0]        rs2_s2;
	logic                    en;

	logic signed [2*DIFF_W-1:0] sqx, sqy;
	logic [DIST2_W-1:0]         d2;

	// Hold the stages while the queue refuses the last one
	assign en         = !v_s3 || !full;
	assign pair.ready = en;
	assign push       = v_s3 && !full;
	assign item       = it_s3;

	assign sqx = (2*DIFF_W)'(it_s1.dx) * (2*DIFF_W)'(it_s1.dx);
	assign sqy = (2*DIFF_W)'(it_s1.dy) * (2*DIFF_W)'(it_s1.dy);
	assign d2  = DIST2_W'(sqx_s2) + DIST2_W'(sqy_s2);

	// Take differences on entry, classify against the radius sum at the end
	always_comb begin
		it_n1      = '0;
		it_n1.disc = pair.data;
		it_n1.dx   = DIFF_W'(pair.data.second_pos_x) - DIFF_W'(pair.data.first_pos_x);
		it_n1.dy   = DIFF_W'(pair.data.second_pos_y) - DIFF_W'(pair.data.first_pos_y);
		it_n1.rs   = RSUM_W'(pair.data.first_radius) + RSUM_W'(pair.data.second_radius);

		it_n3     = it_s2;
		it_n3.d2  = d2[D2_KEEP_W-1:0];
		it_n3.deg = (d2 == '0) || (it_s2.rs == '0);
		it_n3.ov  = (d2 != '0) && (it_s2.rs != '0) && (d2 < DIST2_W'(rs2_s2));
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance payload: differences, then squares, then classification
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= it_n1;
			it_s2  <= it_s1;
			sqx_s2 <= SQ_W'(sqx);
			sqy_s2 <= SQ_W'(sqy);
			rs2_s2 <= RS2_W'(it_s1.rs) * RS2_W'(it_s1.rs);
			it_s3  <= it_n3;
		end
	end

endmodule

FILE: design/bpec_fifo.sv
`timescale 1ns / 1ps
// Short request queue between the front and back parts.
// Depends on bpec_pkg for the item type.
module bpec_fifo import bpec_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	input  logic  pop,
	output item_t rdata,
	output logic  full,
	output logic  empty
);

	item_t              mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store requests
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

FILE: design/bpec_back.sv
`timescale 1ns / 1ps
// Back end: resolves overlap and exchanges normal velocities in a long pipeline.
// Depends on bpec_pkg, bpec_if, bpec_isqrt and bpec_div.
module bpec_back import bpec_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         head,
	input  logic          empty,
	output logic          pop,
	bpec_result_if.source result
);

	localparam int K_DH   = ROOT_W + 1;        // distance known
	localparam int K_OFFP = K_DH + 1;
	localparam int K_OFF  = K_DH + 2;
	localparam int K_N    = K_DH + DIV_Q_W + 1; // unit normal known
	localparam int K_PROD = K_N + 1;
	localparam int K_MOVE = K_N + 2;
	localparam int K_POS  = K_N + 3;
	localparam int K_IMP  = K_POS + DIV_Q_W + 1;
	localparam int K_IPRD = K_IMP + 1;
	localparam int K_VEL  = K_IMP + 2;
	localparam int LAST   = K_IMP + 3;

	typedef struct packed {
		item_t                    it;
		logic [ROOT_W-1:0]        dh;
		logic [ROOT_W-1:0]        depth;
		logic [ROOT_W+GAIN_W-1:0] offp;
		logic [31:0]              off;
		logic signed [18:0]       nx, ny;
		logic signed [DIFF_W-1:0] dvx, dvy;
		logic signed [51:0]       pmx, pmy;
		logic signed [43:0]       pcx, pcy;
		logic signed [22:0]       mx, my;
		logic signed [44:0]       c;
		logic signed [25:0]       np1x, np1y, np2x, np2y;
		logic [DIV_N_W-1:0]       ca1, ca2;
		logic signed [47:0]       i1, i2;
		logic signed [66:0]       q1x, q1y, q2x, q2y;
		logic signed [36:0]       nv1x, nv1y, nv2x, nv2y;
		result_t                  res;
	} bk_t;

	bk_t  stg_s [0:LAST];
	bk_t  nxt   [1:LAST];
	logic v_s   [0:LAST];
	logic en;
	bk_t  load;

	logic [ROOT_W-1:0]  root;
	logic [DIV_N_W-1:0] nnum_x, nnum_y, inum_1, inum_2;
	logic [DIV_D_W-1:0] iden;
	logic [DIV_Q_W-1:0] qn_x, qn_y, qi_1, qi_2;
	logic [DIFF_W-1:0]  dxm, dym;

	// Stall every stage while the output register is held
	assign en           = !v_s[LAST] || result.ready;
	assign pop          = en && !empty;
	assign result.valid = v_s[LAST];
	assign result.data  = stg_s[LAST].res;

	always_comb begin
		load    = '0;
		load.it = head;
	end

	bpec_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x    ({stg_s[0].it.d2, SQRT_SHIFT'(0)}),
		.root (root)
	);

	// Normal components: |d| * 2^30 / dh, rounded (unit normal scaled by 2^16)
	assign dxm    = stg_s[K_DH].it.dx[DIFF_W-1] ? DIFF_W'(-stg_s[K_DH].it.dx)
		: DIFF_W'(stg_s[K_DH].it.dx);
	assign dym    = stg_s[K_DH].it.dy[DIFF_W-1] ? DIFF_W'(-stg_s[K_DH].it.dy)
		: DIFF_W'(stg_s[K_DH].it.dy);
	assign nnum_x = DIV_N_W'({dxm, NORM_SHIFT'(0)}) + DIV_N_W'(stg_s[K_DH].dh >> 1);
	assign nnum_y = DIV_N_W'({dym, NORM_SHIFT'(0)}) + DIV_N_W'(stg_s[K_DH].dh >> 1);

	bpec_div u_div_nx (
		.clk (clk), .en (en), .num (nnum_x), .den (stg_s[K_DH].dh), .quo (qn_x)
	);
	bpec_div u_div_ny (
		.clk (clk), .en (en), .num (nnum_y), .den (stg_s[K_DH].dh), .quo (qn_y)
	);

	// Impulses: 2 * m * c / (m1 + m2), rounded
	assign iden   = DIV_D_W'(stg_s[K_POS].it.rs);
	assign inum_1 = stg_s[K_POS].ca2 + DIV_N_W'(stg_s[K_POS].it.rs >> 1);
	assign inum_2 = stg_s[K_POS].ca1 + DIV_N_W'(stg_s[K_POS].it.rs >> 1);

	bpec_div u_div_i1 (
		.clk (clk), .en (en), .num (inum_1), .den (iden), .quo (qi_1)
	);
	bpec_div u_div_i2 (
		.clk (clk), .en (en), .num (inum_2), .den (iden), .quo (qi_2)
	);

	// Per-stage work; stages without work pass the request on
	always_comb begin
		logic signed [18:0] tx, ty;
		logic signed [47:0] t1, t2;
		logic [44:0]        cm;
		bk_t                p;
		for (int j = 1; j <= LAST; j++) begin
			nxt[j] = stg_s[j-1];
		end

		p = stg_s[K_DH-1];
		nxt[K_DH].dh    = root;
		nxt[K_DH].depth = ROOT_W'({p.it.rs, DEPTH_SHIFT'(0)}) - root;

		p = stg_s[K_OFFP-1];
		nxt[K_OFFP].offp = (ROOT_W+GAIN_W)'(p.depth) * (ROOT_W+GAIN_W)'(SEP_GAIN);

		p = stg_s[K_OFF-1];
		nxt[K_OFF].off = 32'((p.offp + (ROOT_W+GAIN_W)'(1 << (OFF_SHIFT - 1))) >> OFF_SHIFT);

		p  = stg_s[K_N-1];
		tx = 19'(qn_x);
		ty = 19'(qn_y);
		nxt[K_N].nx  = p.it.dx[DIFF_W-1] ? -tx : tx;
		nxt[K_N].ny  = p.it.dy[DIFF_W-1] ? -ty : ty;
		nxt[K_N].dvx = DIFF_W'(p.it.disc.second_vel_x) - DIFF_W'(p.it.disc.first_vel_x);
		nxt[K_N].dvy = DIFF_W'(p.it.disc.second_vel_y) - DIFF_W'(p.it.disc.first_vel_y);

		p = stg_s[K_PROD-1];
		nxt[K_PROD].pmx = 52'($signed({1'b0, p.off})) * 52'(p.nx);
		nxt[K_PROD].pmy = 52'($signed({1'b0, p.off})) * 52'(p.ny);
		nxt[K_PROD].pcx = 44'(p.dvx) * 44'(p.nx);
		nxt[K_PROD].pcy = 44'(p.dvy) * 44'(p.ny);

		p = stg_s[K_MOVE-1];
		nxt[K_MOVE].mx = 23'(round_shift(RND_W'(p.pmx), MOVE_SHIFT));
		nxt[K_MOVE].my = 23'(round_shift(RND_W'(p.pmy), MOVE_SHIFT));
		nxt[K_MOVE].c  = 45'(p.pcx) + 45'(p.pcy);

		p  = stg_s[K_POS-1];
		cm = p.c[44] ? 45'(-p.c) : 45'(p.c);
		nxt[K_POS].np1x = 26'(p.it.disc.first_pos_x) - 26'(p.mx);
		nxt[K_POS].np1y = 26'(p.it.disc.first_pos_y) - 26'(p.my);
		nxt[K_POS].np2x = 26'(p.it.disc.second_pos_x) + 26'(p.mx);
		nxt[K_POS].np2y = 26'(p.it.disc.second_pos_y) + 26'(p.my);
		nxt[K_POS].ca1  = DIV_N_W'({p.it.disc.first_radius, 1'b0}) * DIV_N_W'(cm);
		nxt[K_POS].ca2  = DIV_N_W'({p.it.disc.second_radius, 1'b0}) * DIV_N_W'(cm);

		p  = stg_s[K_IMP-1];
		t1 = 48'(qi_1);
		t2 = 48'(qi_2);
		nxt[K_IMP].i1 = p.c[44] ? -t1 : t1;
		nxt[K_IMP].i2 = p.c[44] ? -t2 : t2;

		p = stg_s[K_IPRD-1];
		nxt[K_IPRD].q1x = 67'(p.i1) * 67'(p.nx);
		nxt[K_IPRD].q1y = 67'(p.i1) * 67'(p.ny);
		nxt[K_IPRD].q2x = 67'(p.i2) * 67'(p.nx);
		nxt[K_IPRD].q2y = 67'(p.i2) * 67'(p.ny);

		p = stg_s[K_VEL-1];
		nxt[K_VEL].nv1x = 37'(p.it.disc.first_vel_x)
			+ 37'(round_shift(RND_W'(p.q1x), IMP_SHIFT));
		nxt[K_VEL].nv1y = 37'(p.it.disc.first_vel_y)
			+ 37'(round_shift(RND_W'(p.q1y), IMP_SHIFT));
		nxt[K_VEL].nv2x = 37'(p.it.disc.second_vel_x)
			- 37'(round_shift(RND_W'(p.q2x), IMP_SHIFT));
		nxt[K_VEL].nv2y = 37'(p.it.disc.second_vel_y)
			- 37'(round_shift(RND_W'(p.q2y), IMP_SHIFT));

		// Pick resolved or passed-through values and saturate
		p = stg_s[LAST-1];
		if (p.it.ov) begin
			nxt[LAST].res.new_first_pos_x  = sat24(40'(p.np1x));
			nxt[LAST].res.new_first_pos_y  = sat24(40'(p.np1y));
			nxt[LAST].res.new_first_vel_x  = sat24(40'(p.nv1x));
			nxt[LAST].res.new_first_vel_y  = sat24(40'(p.nv1y));
			nxt[LAST].res.new_second_pos_x = sat24(40'(p.np2x));
			nxt[LAST].res.new_second_pos_y = sat24(40'(p.np2y));
			nxt[LAST].res.new_second_vel_x = sat24(40'(p.nv2x));
			nxt[LAST].res.new_second_vel_y = sat24(40'(p.nv2y));
		end else begin
			nxt[LAST].res.new_first_pos_x  = p.it.disc.first_pos_x;
			nxt[LAST].res.new_first_pos_y  = p.it.disc.first_pos_y;
			nxt[LAST].res.new_first_vel_x  = p.it.disc.first_vel_x;
			nxt[LAST].res.new_first_vel_y  = p.it.disc.first_vel_y;
			nxt[LAST].res.new_second_pos_x = p.it.disc.second_pos_x;
			nxt[LAST].res.new_second_pos_y = p.it.disc.second_pos_y;
			nxt[LAST].res.new_second_vel_x = p.it.disc.second_vel_x;
			nxt[LAST].res.new_second_vel_y = p.it.disc.second_vel_y;
		end
		nxt[LAST].res.overlapping = p.it.ov;
		nxt[LAST].res.degenerate  = p.it.deg;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= LAST; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= !empty;
			for (int j = 1; j <= LAST; j++) begin
				v_s[j] <= v_s[j-1];
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= load;
			for (int j = 1; j <= LAST; j++) begin
				stg_s[j] <= nxt[j];
			end
		end
	end

endmodule

FILE: design/ball_pair_elastic_collision_core.sv
`timescale 1ns / 1ps
// Elastic collision of two discs: top level joining front, queue and back.
// Depends on bpec_pkg, bpec_if, bpec_front, bpec_fifo and bpec_back.
//
// Usage:
//   pair   (sink)   : one pair of discs per request, taken when valid and ready.
//   result (source) : one result per request, in request order.
// Throughput: one request per clock cycle, sustained while result.ready stays high.
// Pipeline: the accepting edge loads the first of 3 front stages, then 2 more
//   front stages, the queue register and 135 back stages, set by the
//   31-stage square root and two 47-stage pipelined dividers in series.
// Reset (arst_n low) empties all pipelines and the queue; no results are
//   pending afterwards and the block accepts requests at once.
// Receiver stall: the back pipeline holds while result.valid is high and
//   result.ready is low; the front keeps taking requests until the 4-entry
//   queue is full and its last stage holds a request, then drops pair.ready
//   until the back moves again.
// Discs that do not overlap, or that are degenerate, pass through unchanged.
module ball_pair_elastic_collision_core import bpec_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bpec_pair_if.sink     pair,
	bpec_result_if.source result
);

	logic  push, pop, full, empty;
	item_t wr_item, rd_item;

	bpec_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.push   (push),
		.item   (wr_item),
		.full   (full)
	);

	bpec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_item),
		.pop    (pop),
		.rdata  (rd_item),
		.full   (full),
		.empty  (empty)
	);

	bpec_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (rd_item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
